/* rtl/core/tcrc_pkg.sv */
// shared types, codes and the byte-wide crc update for the compact row hash
package tcrc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_FORMAT_CLASS   = 3'd0;
    localparam logic [2:0] CFG_SURFACE_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_SURFACE_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_ROW_PITCH      = 3'd3;

    // format class codes
    localparam logic [2:0] FMT_BLOCK8  = 3'd0;
    localparam logic [2:0] FMT_BLOCK16 = 3'd1;
    localparam logic [2:0] FMT_BPP1    = 3'd2;
    localparam logic [2:0] FMT_BPP4    = 3'd5;
    localparam logic [2:0] FMT_UNKNOWN = 3'd6;

    // reflected crc-32
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // derived surface layout
    typedef struct packed {
        logic [16:0] pitch;
        logic [14:0] rows;
        logic [16:0] compact;
    } layout_t;

    // one byte through the reflected crc, one bit a step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

/* rtl/core/texture_compact_row_crc32_hash_core.sv */
// compact row crc-32 hash of a texture surface, streamed one byte per item
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+-----------------------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//  in      | in_valid, in_ready, data_byte             | in_valid & in_ready
//  out     | out_valid, out_ready, hash_value          | out_valid & out_ready
//
// one byte item per cycle sustained while in_ready stays high; the byte crc update
// sits between the input register and the crc / result registers, so the hash of a
// surface goes from its last byte in the input register to the result register.
// reset clears the configuration to its defaults and the stream state to a
// fresh surface. in_ready drops after a configuration write while the layout
// register reloads, and when the byte in the input register ends a surface while
// the previous hash still waits on out_ready.
module texture_compact_row_crc32_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    tcrc_pkg::layout_t layout;
    logic              cfg_pending;

    logic        in_vld_reg;
    logic [7:0]  data_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [16:0] col_reg;
    logic [16:0] col_next;
    logic [14:0] row_reg;
    logic [14:0] row_next;
    logic        out_vld_reg;
    logic        out_vld_next;
    logic [31:0] hash_reg;

    logic        in_acc;
    logic        adv;
    logic [17:0] col_plus;
    logic [15:0] row_plus;
    logic        row_end;
    logic        surf_end;
    logic [31:0] crc_upd;

    // configuration and layout
    tcrc_layout u_layout (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .layout    (layout),
        .pending   (cfg_pending)
    );

    // row and surface end from the counters
    always_comb
    begin
        col_plus = {1'b0, col_reg} + 18'd1;
        row_plus = {1'b0, row_reg} + 16'd1;
        row_end  = col_plus >= {1'b0, layout.pitch};
        surf_end = row_end && (row_plus >= {1'b0, layout.rows});
        crc_upd  = (col_reg < layout.compact) ? tcrc_pkg::crc_byte(crc_reg, data_reg)
                                              : crc_reg;
    end

    // handshake: stage advances unless its hash would overwrite a waiting one
    assign adv      = in_vld_reg && (!surf_end || !out_vld_reg || out_ready);
    assign in_ready = !cfg_pending && (!in_vld_reg || adv);
    assign in_acc   = in_valid && in_ready;

    // next stream state
    always_comb
    begin
        crc_next     = crc_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        out_vld_next = out_vld_reg && !out_ready;
        if (adv)
        begin
            if (!row_end)
            begin
                crc_next = crc_upd;
                col_next = col_plus[16:0];
            end
            else if (surf_end)
            begin
                crc_next     = tcrc_pkg::CRC_INIT;
                col_next     = 17'd0;
                row_next     = 15'd0;
                out_vld_next = 1'b1;
            end
            else
            begin
                crc_next = crc_upd;
                col_next = 17'd0;
                row_next = row_plus[14:0];
            end
        end
    end

    // control and stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            crc_reg     <= tcrc_pkg::CRC_INIT;
            col_reg     <= 17'd0;
            row_reg     <= 15'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_vld_reg <= 1'b0;
            end
            crc_reg     <= crc_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            data_reg <= data_byte;
        end
        if (adv && surf_end)
        begin
            hash_reg <= crc_upd;
        end
    end

    assign out_valid  = out_vld_reg;
    assign hash_value = hash_reg;

    // no input taken while the layout reloads
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_pending |-> !in_ready)
        else $error("item accepted during layout reload");

    // a finishing byte never overwrites a hash still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && surf_end) |-> (!out_vld_reg || out_ready))
        else $error("hash overwritten");

    // surface end restarts the stream and presents a hash
    a_surface_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && surf_end) |=> (out_vld_reg && col_reg == 17'd0 && row_reg == 15'd0
                              && crc_reg == tcrc_pkg::CRC_INIT))
        else $error("stream state not restarted after surface end");

    // stream state moves only when a byte advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(crc_reg) && $stable(col_reg) && $stable(row_reg)))
        else $error("stream state changed without a byte");

endmodule

/* rtl/core/tcrc_layout.sv */
// configuration registers and registered row count / compact length derivation
module tcrc_layout (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [16:0]           cfg_data,
    output logic                  cfg_ready,
    output tcrc_pkg::layout_t     layout,
    output logic                  pending
);

    logic [2:0]  cls_reg;
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic [16:0] pitch_cfg_reg;
    logic        pend_reg;
    tcrc_pkg::layout_t layout_reg;
    tcrc_pkg::layout_t layout_next;

    logic        cfg_wr;
    logic [15:0] h_sum;
    logic [15:0] w_sum;
    logic [13:0] blk_rows;
    logic [13:0] blk_cols;
    logic [2:0]  bpp;
    logic [17:0] len_raw;
    logic [14:0] rows_raw;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg       <= tcrc_pkg::FMT_UNKNOWN;
            width_reg     <= 15'd1;
            height_reg    <= 15'd1;
            pitch_cfg_reg <= 17'd4;
            pend_reg      <= 1'b0;
        end
        else
        begin
            pend_reg <= cfg_wr;
            if (cfg_wr)
            begin
                case (cfg_index)
                    tcrc_pkg::CFG_FORMAT_CLASS:   cls_reg       <= cfg_data[2:0];
                    tcrc_pkg::CFG_SURFACE_WIDTH:  width_reg     <= cfg_data[14:0];
                    tcrc_pkg::CFG_SURFACE_HEIGHT: height_reg    <= cfg_data[14:0];
                    tcrc_pkg::CFG_ROW_PITCH:      pitch_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // layout from the current register values
    always_comb
    begin
        h_sum    = {1'b0, height_reg} + 16'd3;
        w_sum    = {1'b0, width_reg} + 16'd3;
        blk_rows = h_sum[15:2];
        blk_cols = (w_sum[15:2] == 14'd0) ? 14'd1 : w_sum[15:2];
        bpp      = 3'(cls_reg - tcrc_pkg::FMT_BPP1) + 3'd1;

        layout_next.pitch = (pitch_cfg_reg == 17'd0) ? 17'd1 : pitch_cfg_reg;

        if (cls_reg inside {tcrc_pkg::FMT_BLOCK8, tcrc_pkg::FMT_BLOCK16})
        begin
            rows_raw = {1'b0, blk_rows};
            len_raw  = (cls_reg == tcrc_pkg::FMT_BLOCK8) ? {1'b0, blk_cols, 3'b000}
                                                         : {blk_cols, 4'b0000};
        end
        else if (cls_reg inside {[tcrc_pkg::FMT_BPP1:tcrc_pkg::FMT_BPP4]})
        begin
            rows_raw = height_reg;
            len_raw  = 18'(width_reg) * 18'(bpp);
        end
        else
        begin
            rows_raw = height_reg;
            len_raw  = {1'b0, layout_next.pitch};
        end

        layout_next.rows    = (rows_raw == 15'd0) ? 15'd1 : rows_raw;
        layout_next.compact = (len_raw > {1'b0, layout_next.pitch}) ? layout_next.pitch
                                                                    : len_raw[16:0];
    end

    // layout register, loaded from the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg.pitch   <= 17'd4;
            layout_reg.rows    <= 15'd1;
            layout_reg.compact <= 17'd4;
        end
        else
        begin
            layout_reg <= layout_next;
        end
    end

    assign layout  = layout_reg;
    assign pending = pend_reg;

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the compact row crc-32 texture hash core
module tb;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned BYTE_TARGET  = 1350;
    localparam int unsigned BYTE_SLACK   = 100;
    localparam int unsigned CALM_FROM    = 1150;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DIM_TOP      = 32767;
    localparam logic [2:0]  FMT_SPARE    = 3'd7;
    localparam logic [2:0]  CFG_INDEX_TOP = 3'd7;
    localparam logic [16:0] REG_ALL_ONES = 17'h1FFFF;

    // surface layout tracker, crc predictor and queue of pending hashes
    class hash_board;
        logic [2:0]  fmt;
        logic [14:0] width;
        logic [14:0] height;
        logic [16:0] pitch_reg;
        logic [31:0] crc;
        int unsigned col;
        int unsigned row;
        logic [31:0] pending[$];
        int unsigned errors;

        function new();
            fmt = tcrc_pkg::FMT_UNKNOWN;
            width = 15'd1;
            height = 15'd1;
            pitch_reg = 17'd4;
            errors = 0;
            restart();
        endfunction

        function void restart();
            crc = tcrc_pkg::CRC_INIT;
            col = 0;
            row = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [16:0] val);
            case (idx)
                tcrc_pkg::CFG_FORMAT_CLASS:   fmt = val[2:0];
                tcrc_pkg::CFG_SURFACE_WIDTH:  width = val[14:0];
                tcrc_pkg::CFG_SURFACE_HEIGHT: height = val[14:0];
                tcrc_pkg::CFG_ROW_PITCH:      pitch_reg = val;
                default: ;
            endcase
        endfunction

        // pitch, row count and hashed bytes per row from the current registers
        function void shape(output int unsigned pitch, output int unsigned rows,
                            output int unsigned compact);
            pitch = (pitch_reg == 0) ? 1 : pitch_reg;
            if (fmt == tcrc_pkg::FMT_BLOCK8 || fmt == tcrc_pkg::FMT_BLOCK16)
            begin
                rows = (int'(height) + 3) / 4;
                compact = (int'(width) + 3) / 4;
                if (compact == 0)
                    compact = 1;
                compact = compact * ((fmt == tcrc_pkg::FMT_BLOCK8) ? 8 : 16);
            end
            else if (fmt >= tcrc_pkg::FMT_BPP1 && fmt <= tcrc_pkg::FMT_BPP4)
            begin
                rows = height;
                compact = int'(width) * (int'(fmt) - int'(tcrc_pkg::FMT_BPP1) + 1);
            end
            else
            begin
                rows = height;
                compact = pitch;
            end
            if (rows == 0)
                rows = 1;
            if (compact > pitch)
                compact = pitch;
        endfunction

        // reflected crc, one bit a step with the data bit folded into feedback
        function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
            logic [31:0] r;
            r = acc;
            for (int k = 0; k < 8; k++)
            begin
                if (r[0] ^ b[k])
                    r = (r >> 1) ^ tcrc_pkg::CRC_POLY;
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        // accepted byte item: advance the scan position, queue a hash at surface end
        function void note_byte(logic [7:0] b);
            int unsigned pitch;
            int unsigned rows;
            int unsigned compact;
            shape(pitch, rows, compact);
            if (col < compact)
                crc = crc_step(crc, b);
            if (col + 1 < pitch)
                col++;
            else if (row + 1 >= rows)
            begin
                pending = {pending, crc};
                restart();
            end
            else
            begin
                col = 0;
                row++;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_hash(logic [31:0] got);
            logic [31:0] want;
            if (pending.size() == 0)
                report($sformatf("hash %h with none pending", got));
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                    report($sformatf("hash_value %h, predicted %h", got, want));
            end
        endtask

        // bytes still to come before the current surface ends
        function int unsigned bytes_left();
            int unsigned pitch;
            int unsigned rows;
            int unsigned compact;
            shape(pitch, rows, compact);
            return ((col + 1 >= pitch) ? 1 : pitch - col)
                 + ((row + 1 >= rows) ? 0 : (rows - 1 - row) * pitch);
        endfunction

        function int unsigned surface_bytes();
            int unsigned pitch;
            int unsigned rows;
            int unsigned compact;
            shape(pitch, rows, compact);
            return rows * pitch;
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] hash_value;

    hash_board   board = new();
    int unsigned pushed = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    bit          jitter_on = 1'b0;

    texture_compact_row_crc32_hash_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // hash receiver: check accepted items, then pick out_ready for the next cycle
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_hash(hash_value);
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (jitter_on && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end
        else
            out_ready <= 1'b1;
    end

    // one register write; cfg_valid stays up for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, val);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
    endtask

    // one byte item, with an optional gap ahead of it
    task automatic push_byte(input logic [7:0] b);
        if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_byte(b);
        pushed++;
    endtask

    task automatic push_random(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // stop sending, wait for every pending hash and let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (!board.drained())
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        int unsigned total;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        jitter_on = 1'b1;

        // reset layout: unknown format, one row of four bytes
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h01);
        settle();

        // format seven, zero pitch and zero height: each byte is a surface
        write_reg(tcrc_pkg::CFG_FORMAT_CLASS, 17'(FMT_SPARE));
        write_reg(tcrc_pkg::CFG_ROW_PITCH, 17'd0);
        write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, 17'd0);
        cfg_done();
        push_byte(8'hFF);
        push_byte(8'h00);
        settle();

        // block8: five lines give two block rows, compact capped at the pitch
        write_reg(tcrc_pkg::CFG_FORMAT_CLASS, 17'(tcrc_pkg::FMT_BLOCK8));
        write_reg(tcrc_pkg::CFG_SURFACE_WIDTH, 17'd1);
        write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, 17'd5);
        write_reg(tcrc_pkg::CFG_ROW_PITCH, 17'd3);
        cfg_done();
        push_random(6);
        settle();

        // zero width pixel format hashes nothing
        write_reg(tcrc_pkg::CFG_FORMAT_CLASS, 17'(tcrc_pkg::FMT_BPP1));
        write_reg(tcrc_pkg::CFG_SURFACE_WIDTH, 17'd0);
        write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, 17'd1);
        write_reg(tcrc_pkg::CFG_ROW_PITCH, 17'd2);
        cfg_done();
        push_random(2);
        settle();

        // largest values, then the layout shrinks under the surface in flight
        write_reg(tcrc_pkg::CFG_FORMAT_CLASS, 17'(tcrc_pkg::FMT_BLOCK16));
        write_reg(tcrc_pkg::CFG_SURFACE_WIDTH, REG_ALL_ONES);
        write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, REG_ALL_ONES);
        write_reg(tcrc_pkg::CFG_ROW_PITCH, REG_ALL_ONES);
        cfg_done();
        push_random(3);
        settle();
        write_reg(tcrc_pkg::CFG_ROW_PITCH, 17'd2);
        write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, 17'd1);
        cfg_done();
        push_random(1);
        settle();

        // row count runs past the end once the height drops
        write_reg(tcrc_pkg::CFG_FORMAT_CLASS, 17'(tcrc_pkg::FMT_BPP1 + 3'd1));
        write_reg(tcrc_pkg::CFG_SURFACE_WIDTH, 17'd2);
        write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, 17'd5);
        cfg_done();
        push_random(4);
        settle();
        write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, 17'd1);
        cfg_done();
        push_random(2);
        settle();

        // receiver holds off while one-byte surfaces pile up behind it
        jitter_on = 1'b0;
        write_reg(tcrc_pkg::CFG_FORMAT_CLASS, 17'(tcrc_pkg::FMT_UNKNOWN));
        write_reg(tcrc_pkg::CFG_ROW_PITCH, 17'd1);
        cfg_done();
        hold_left = HOLD_CYCLES;
        push_random(40);
        settle();

        // random layouts, mostly whole surfaces, some cut short or overrun
        while (pushed < BYTE_TARGET)
        begin
            jitter_on = (pushed < CALM_FROM) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 1))
                write_reg(tcrc_pkg::CFG_FORMAT_CLASS, 17'($urandom_range(0, FMT_SPARE)));
            if ($urandom_range(0, 1))
                write_reg(tcrc_pkg::CFG_SURFACE_WIDTH, ($urandom_range(0, 15) == 0)
                          ? 17'($urandom_range(0, DIM_TOP)) : 17'($urandom_range(0, 20)));
            if ($urandom_range(0, 1))
                write_reg(tcrc_pkg::CFG_SURFACE_HEIGHT, ($urandom_range(0, 19) == 0)
                          ? 17'($urandom_range(9, 40)) : 17'($urandom_range(0, 8)));
            if ($urandom_range(0, 1))
                write_reg(tcrc_pkg::CFG_ROW_PITCH, ($urandom_range(0, 9) == 0)
                          ? 17'($urandom_range(17, 200)) : 17'($urandom_range(0, 16)));
            if ($urandom_range(0, 11) == 0)
                write_reg(3'($urandom_range(tcrc_pkg::CFG_ROW_PITCH + 1, CFG_INDEX_TOP)),
                          17'($urandom));
            cfg_done();
            total = board.bytes_left() + $urandom_range(0, 2) * board.surface_bytes();
            if (total > 1500)
                total = $urandom_range(1, 60);
            else if ($urandom_range(0, 4) == 0)
                total = $urandom_range(1, total + 4);
            // keep the run close to the item budget
            if (pushed + total > BYTE_TARGET + BYTE_SLACK)
                total = BYTE_TARGET + BYTE_SLACK - pushed;
            push_random(total);
            settle();
        end

        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
